// ===== rtl/assert_macros.svh =====
// assertion helper macros for the block allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BBA_ASSERT(lbl, cond, msg)
`define BBA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
// constants, codes and helper functions for the block allocator
`timescale 1ns / 1ps
package bba_pkg;
  localparam int NUM_BLOCKS      = 4096;
  localparam int WORD_BITS       = 32;
  localparam int RESERVED_BLOCKS = 1;
  localparam int WORD_COUNT      = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W         = $clog2(WORD_COUNT);
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int BLK_W           = 12;
  localparam int CNT_W           = 13;
  localparam int STATUS_W        = 2;

  localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

  localparam logic                FUNC_ALLOC   = 1'b0;
  localparam logic                FUNC_FREE    = 1'b1;
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam int RESERVED_CAP = (RESERVED_BLOCKS < NUM_BLOCKS) ? RESERVED_BLOCKS : NUM_BLOCKS;

  // offset of the first zero bit counted from the msb
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] k;
    k = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[WORD_BITS-1-i]) begin
        k = BIT_W'(i);
      end
    end
    return k;
  endfunction

  // bitmap word after reset: reserved low blocks marked used
  function automatic logic [WORD_BITS-1:0] reset_word(input logic [WADDR_W-1:0] w);
    logic [WORD_BITS-1:0] word;
    word = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if ((int'(w) * WORD_BITS + b) < RESERVED_CAP) begin
        word[WORD_BITS-1-b] = 1'b1;
      end
    end
    return word;
  endfunction
endpackage

// ===== rtl/bba_req_if.sv =====
// request channel: operation and block index
`timescale 1ns / 1ps
interface bba_req_if
  import bba_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [BLK_W-1:0] block_index;

  modport source (output valid, output func, output block_index, input ready);
  modport sink   (input valid, input func, input block_index, output ready);
endinterface

// ===== rtl/bba_rsp_if.sv =====
// result channel: status, granted block and used count
`timescale 1ns / 1ps
interface bba_rsp_if
  import bba_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BLK_W-1:0]    granted_block;
  logic [CNT_W-1:0]    blocks_in_use;

  modport source (output valid, output status, output granted_block, output blocks_in_use,
                  input ready);
  modport sink   (input valid, input status, input granted_block, input blocks_in_use,
                  output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/bitmap_block_allocator_unit.sv =====
// top level: first-fit block allocator over a bitmap held in ram
// Usage: requests arrive on in_ch (func, block_index), one result per request
// leaves on out_ch (status, granted_block, blocks_in_use). Both are valid/ready.
// After rst_n is released the bitmap ram is written with its reset pattern, one
// word a cycle, for all 128 words; in_ch.ready stays low during that pass.
// One request is handled at a time. An allocate reads one bitmap word per
// cycle from the start of the bitmap until a word with a free bit shows up
// or the last of the 128 words has been read, through the single ram read port.
// A free reads one word and writes it back with the block's bit cleared if it
// was set; a free of an out-of-range block index reads no word.
// The result sits in an output register; while the receiver stalls the next
// request may be accepted and worked, and its result waits until the output
// register is taken. Reset clears the counter to the reserved block count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bba_req_if.sink   in_ch,
  bba_rsp_if.source out_ch
);
  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_FREE_CHK, ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [WADDR_W-1:0]  word_r, word_nxt;
  logic [BLK_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    used_cnt_r, used_cnt_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [BLK_W-1:0]    res_grant_r, res_grant_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BLK_W-1:0]    out_grant_r, out_grant_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                ram_we;
  logic [WADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                in_fire;
  logic                word_found;
  logic [BIT_W-1:0]    zero_pos;
  logic [BLK_W-1:0]    cand_blk;
  logic [BIT_W-1:0]    free_pos;
  logic [WORD_BITS-1:0] free_mask;

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign word_found = (ram_rdata != WORD_FULL);
  assign zero_pos   = first_zero(ram_rdata);
  assign cand_blk   = BLK_W'({word_r, zero_pos});
  assign free_pos   = BIT_W'(WORD_BITS - 1) - idx_r[BIT_W-1:0];
  assign free_mask  = WORD_BITS'(1) << free_pos;

  always_comb begin
    state_nxt      = state_r;
    word_nxt       = word_r;
    idx_nxt        = idx_r;
    used_cnt_nxt   = used_cnt_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = word_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = word_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = reset_word(word_r);
        word_nxt  = word_r + 1'b1;
        if (word_r == WADDR_W'(WORD_COUNT - 1)) begin
          word_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt        = in_ch.block_index;
          res_status_nxt = STATUS_OK;
          res_grant_nxt  = '0;
          if (in_ch.func == FUNC_FREE) begin
            if ({1'b0, in_ch.block_index} >= CNT_W'(NUM_BLOCKS)) begin
              res_status_nxt = STATUS_RANGE;
              state_nxt      = ST_DONE;
            end else begin
              ram_raddr = WADDR_W'(in_ch.block_index >> BIT_W);
              word_nxt  = WADDR_W'(in_ch.block_index >> BIT_W);
              state_nxt = ST_FREE_CHK;
            end
          end else begin
            ram_raddr = '0;
            word_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata holds word_r; the next word is read ahead
        ram_raddr = word_r + 1'b1;
        if (word_found) begin
          state_nxt = ST_DONE;
          if ({1'b0, cand_blk} < CNT_W'(NUM_BLOCKS)) begin
            ram_we        = 1'b1;
            ram_waddr     = word_r;
            ram_wdata     = ram_rdata | (WORD_BITS'(1) << (BIT_W'(WORD_BITS - 1) - zero_pos));
            used_cnt_nxt  = used_cnt_r + 1'b1;
            res_grant_nxt = cand_blk;
          end else begin
            // only a padding bit is free
            res_status_nxt = STATUS_FULL;
          end
        end else if (word_r == WADDR_W'(WORD_COUNT - 1)) begin
          res_status_nxt = STATUS_FULL;
          state_nxt      = ST_DONE;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      ST_FREE_CHK: begin
        state_nxt = ST_DONE;
        if ((ram_rdata & free_mask) != '0) begin
          ram_we    = 1'b1;
          ram_waddr = word_r;
          ram_wdata = ram_rdata & ~free_mask;
          if (used_cnt_r != '0) begin
            used_cnt_nxt = used_cnt_r - 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_grant_nxt  = res_grant_r;
          out_cnt_nxt    = used_cnt_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      word_r      <= '0;
      used_cnt_r  <= CNT_W'(RESERVED_CAP);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_block = out_grant_r;
  assign out_ch.blocks_in_use = out_cnt_r;

  `BBA_ASSERT(a_cnt_bound, used_cnt_r <= CNT_W'(NUM_BLOCKS), "used count above block count")
  `BBA_ASSERT(a_we_state,
              !ram_we || state_r == ST_INIT || state_r == ST_SCAN || state_r == ST_FREE_CHK,
              "bitmap write outside a working state")
  `BBA_ASSERT_NEXT(a_scan_hit, state_r == ST_SCAN && word_found, state_r == ST_DONE,
                   "scan hit did not finish the request")
  `BBA_ASSERT_NEXT(a_cnt_hold, state_r == ST_IDLE || state_r == ST_DONE, $stable(used_cnt_r),
                   "used count moved while no request was worked")
endmodule
